/* sv/sakg_pkg.sv */
package sakg_pkg;

	// negative response codes, renumbered
	localparam logic [2:0] NRC_LENGTH      = 3'd0;
	localparam logic [2:0] NRC_UNSUPPORTED = 3'd1;
	localparam logic [2:0] NRC_SEQUENCE    = 3'd2;
	localparam logic [2:0] NRC_INVALID_KEY = 3'd3;
	localparam logic [2:0] NRC_ATTEMPTS    = 3'd4;
	localparam logic [2:0] NRC_DELAY       = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_DELAY_TICKS      = 2'd0;
	localparam logic [1:0] CFG_ATTEMPT_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_SEED_SUBFUNCTION = 2'd2;

	// configuration reset values
	localparam logic [15:0] DELAY_TICKS_RST      = 16'd10000;
	localparam logic [7:0]  ATTEMPT_LIMIT_RST    = 8'd3;
	localparam logic [6:0]  SEED_SUBFUNCTION_RST = 7'd3;

	// item kinds
	localparam logic REQ_TYPE_TICK = 1'b1;

	// reply constants
	localparam logic [7:0]  SID_SEED_REPLY  = 8'h67;
	localparam logic [7:0]  SID_POS_OFFSET  = 8'h40;
	localparam logic [7:0]  ATTEMPT_MAX     = 8'hFF;
	localparam logic [16:0] TICK_MAX        = 17'h1FFFF;
	localparam logic [11:0] LEN_MIN         = 12'd2;
	localparam logic [11:0] LEN_SEED        = 12'd2;
	localparam logic [11:0] LEN_KEY         = 12'd4;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  service_id;
		logic [7:0]  sub_function_byte;
		logic [11:0] message_length;
		logic [15:0] received_key;
		logic [15:0] random_seed;
		logic [15:0] expected_key;
	} req_t;

	typedef struct packed {
		logic        positive;
		logic [7:0]  response_sid;
		logic [7:0]  response_sub_function;
		logic        carries_seed;
		logic [15:0] seed_value;
		logic [2:0]  nrc_code;
		logic        unlocked_level;
	} rsp_t;

	typedef struct packed {
		logic [15:0] delay_ticks;
		logic [7:0]  attempt_limit;
		logic [6:0]  seed_subfunction;
	} cfg_t;

endpackage

/* sv/sakg_stream_if.sv */
interface sakg_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/sakg_cfg.sv */
module sakg_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata,
	output sakg_pkg::cfg_t    cfg
);
	import sakg_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks      <= DELAY_TICKS_RST;
			cfg_q.attempt_limit    <= ATTEMPT_LIMIT_RST;
			cfg_q.seed_subfunction <= SEED_SUBFUNCTION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELAY_TICKS: begin
					cfg_q.delay_ticks <= cfg_wdata;
				end
				CFG_ATTEMPT_LIMIT: begin
					cfg_q.attempt_limit <= cfg_wdata[7:0];
				end
				CFG_SEED_SUBFUNCTION: begin
					cfg_q.seed_subfunction <= cfg_wdata[6:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/sakg_core.sv */
module sakg_core (
	input  logic            clk,
	input  logic            arst_n,
	input  sakg_pkg::cfg_t  cfg,
	input  sakg_pkg::req_t  item,
	input  logic            adv,
	output logic            produce,
	output sakg_pkg::rsp_t  result
);
	import sakg_pkg::*;

	logic        level_q, level_n;
	logic        seed_active_q, seed_active_n;
	logic [6:0]  saved_sf_q, saved_sf_n;
	logic [7:0]  attempt_q, attempt_n;
	logic [16:0] elapsed_q, elapsed_n;
	logic        pass_q, pass_n;
	logic [6:0]  sf;
	logic [7:0]  bumped;

	// odd sub-function matches the level, even one matches its seed partner
	function automatic logic is_supported(input logic [6:0] s, input logic [6:0] seed_sf);
		logic [6:0] odd;
		odd = s[0] ? s : (s - 7'd1);
		return (s != 7'd0) && (odd == seed_sf);
	endfunction

	assign sf     = item.sub_function_byte[6:0];
	assign bumped = (attempt_q == ATTEMPT_MAX) ? ATTEMPT_MAX : (attempt_q + 8'd1);

	// request decision and next state
	always_comb begin
		level_n       = level_q;
		seed_active_n = seed_active_q;
		saved_sf_n    = saved_sf_q;
		attempt_n     = attempt_q;
		elapsed_n     = elapsed_q;
		pass_n        = pass_q;
		produce       = 1'b1;

		result.positive              = 1'b0;
		result.response_sid          = item.service_id;
		result.response_sub_function = 8'd0;
		result.carries_seed          = 1'b0;
		result.seed_value            = 16'd0;
		result.nrc_code              = NRC_LENGTH;

		if (item.req_type == REQ_TYPE_TICK) begin
			produce = 1'b0;
			if (elapsed_q != TICK_MAX) begin
				elapsed_n = elapsed_q + 17'd1;
			end
		end else if (item.message_length < LEN_MIN) begin
			result.nrc_code = NRC_LENGTH;
		end else if (!is_supported(sf, cfg.seed_subfunction)) begin
			result.nrc_code = NRC_UNSUPPORTED;
		end else if (sf[0]) begin
			// seed request
			if (level_q) begin
				seed_active_n                = 1'b0;
				result.positive              = 1'b1;
				result.response_sid          = SID_SEED_REPLY;
				result.response_sub_function = {1'b0, sf};
				result.carries_seed          = 1'b1;
			end else if (!seed_active_q && (item.message_length != LEN_SEED)) begin
				result.nrc_code = NRC_LENGTH;
			end else if (!seed_active_q && (elapsed_q <= {1'b0, cfg.delay_ticks})) begin
				result.nrc_code = NRC_DELAY;
			end else begin
				if (!seed_active_q) begin
					if (!pass_q) begin
						attempt_n = 8'd0;
					end
					pass_n = 1'b1;
				end
				seed_active_n                = 1'b1;
				saved_sf_n                   = sf;
				result.positive              = 1'b1;
				result.response_sid          = SID_SEED_REPLY;
				result.response_sub_function = {1'b0, sf};
				result.carries_seed          = 1'b1;
				result.seed_value            = item.random_seed;
			end
		end else begin
			// key send
			if (!seed_active_q) begin
				result.nrc_code = NRC_SEQUENCE;
			end else begin
				seed_active_n = 1'b0;
				attempt_n     = bumped;
				if ({1'b0, sf} != ({1'b0, saved_sf_q} + 8'd1)) begin
					result.nrc_code = NRC_SEQUENCE;
				end else if (item.message_length != LEN_KEY) begin
					result.nrc_code = NRC_LENGTH;
				end else if (item.received_key == item.expected_key) begin
					attempt_n                    = 8'd0;
					level_n                      = is_supported(saved_sf_q,
						cfg.seed_subfunction);
					result.positive              = 1'b1;
					result.response_sid          = item.service_id + SID_POS_OFFSET;
					result.response_sub_function = item.sub_function_byte;
				end else if (bumped < cfg.attempt_limit) begin
					result.nrc_code = NRC_INVALID_KEY;
				end else begin
					elapsed_n       = 17'd0;
					pass_n          = 1'b0;
					result.nrc_code = NRC_ATTEMPTS;
				end
			end
		end

		result.unlocked_level = level_n;
	end

	// state update once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= 1'b0;
			seed_active_q <= 1'b0;
			saved_sf_q    <= 7'd0;
			attempt_q     <= 8'd0;
			elapsed_q     <= 17'd0;
			pass_q        <= 1'b0;
		end else if (adv) begin
			level_q       <= level_n;
			seed_active_q <= seed_active_n;
			saved_sf_q    <= saved_sf_n;
			attempt_q     <= attempt_n;
			elapsed_q     <= elapsed_n;
			pass_q        <= pass_n;
		end
	end

`ifndef SYNTH
	// a tick touches only the timer
	a_tick_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item.req_type == REQ_TYPE_TICK) |=>
		($stable(level_q) && $stable(seed_active_q) && $stable(attempt_q)))
		else $error("tick changed access state");

	// a good key clears the failure count
	a_unlock_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && produce && result.positive && !result.carries_seed) |=> (attempt_q == 8'd0))
		else $error("attempt count not cleared after key accepted");

	// lockout restarts the delay timer
	a_lockout_restarts_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && produce && !result.positive && result.nrc_code == NRC_ATTEMPTS) |=>
		(elapsed_q == 17'd0 && !pass_q))
		else $error("lockout did not restart delay");
`endif

endmodule

/* sv/seed_key_access_guard.sv */
// channel  | direction | payload
// ---------+-----------+-------------------------------------------
// req      | in        | tick or security access request (req_t)
// rsp      | out       | positive or negative reply (rsp_t)
// cfg      | in        | write enable, register index, write data
//
// one item per cycle sustained unless a stalled reply holds the flow; a reply
// to a taken item passes through the input register and the result register
// ticks update the lockout timer and give no reply
// reset clears the access state and loads the default configuration
// a stalled reply holds; the input register still takes a tick meanwhile
module seed_key_access_guard (
	input  logic        clk,
	input  logic        arst_n,
	sakg_stream_if.sink   req,
	sakg_stream_if.source rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import sakg_pkg::*;

	cfg_t  cfg;
	req_t  item_s1;
	logic  s1_valid_q;
	rsp_t  result;
	logic  produce;
	rsp_t  rsp_s2;
	logic  rsp_valid_q;
	logic  out_free;
	logic  adv;

	sakg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sakg_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.adv     (adv),
		.produce (produce),
		.result  (result)
	);

	// handshake control
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign adv       = s1_valid_q && (!produce || out_free);
	assign req.ready = !s1_valid_q || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= (req.valid && req.ready) || (s1_valid_q && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv && produce) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			rsp_s2 <= result;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_s2;

`ifndef SYNTH
	// input side stalls only with an item held
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> s1_valid_q)
		else $error("input stalled with empty stage");

	// a tick never raises a reply
	a_tick_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !produce && !(rsp_valid_q && !rsp.ready)) |=> !rsp_valid_q)
		else $error("reply produced for a tick");

	// a held item waits only for the result register
	a_hold_only_on_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !adv) |-> (rsp_valid_q && !rsp.ready && produce))
		else $error("item held without output back pressure");
`endif

endmodule

/* test/seed_key_access_guard_tb.sv */
`timescale 1ns / 1ps

module seed_key_access_guard_tb;
	import sakg_pkg::*;

	localparam logic [7:0] SID_SECURITY_ACCESS = 8'h27;
	localparam int PRINT_CAP = 30;
	localparam int LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	sakg_stream_if #(.payload_t(req_t)) req_if ();
	sakg_stream_if #(.payload_t(rsp_t)) rsp_if ();

	seed_key_access_guard uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// stimulus and scoreboard storage
	req_t pending_reqs[$];
	rsp_t expected_replies[$];
	int   mismatches = 0;
	int   items_queued = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   rsp_hold_cycles = 0;
	bit   hold_start = 1'b0;
	bit   hold_loaded = 1'b0;
	bit   unlock_ok = 1'b0;
	logic req_fire = 1'b0;
	rsp_t predicted;

	// configuration copy
	logic [15:0] cfg_delay;
	logic [7:0]  cfg_limit;
	logic [6:0]  cfg_seed_sf;

	// access state copy
	logic        lvl_unlocked;
	logic        seed_out;
	logic [7:0]  saved_sf;
	logic [15:0] held_seed;
	logic [7:0]  fail_count;
	logic [16:0] tick_count;
	logic        delay_passed;

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sub-function belongs to the configured level (odd seed, even key)
	function automatic bit sf_supported(logic [7:0] sf);
		logic [7:0] odd;
		if (sf == 8'd0)
			return 1'b0;
		odd = sf[0] ? sf : sf - 8'd1;
		return odd == {1'b0, cfg_seed_sf};
	endfunction

	// next access state and reply for one transaction; returns 1 if a reply is due
	function automatic bit predict_reply(input req_t r, output rsp_t o);
		logic [7:0] sf;
		logic [2:0] code;
		bit         neg;
		o = '0;
		sf = {1'b0, r.sub_function_byte[6:0]};
		if (r.req_type == REQ_TYPE_TICK) begin
			if (tick_count != TICK_MAX)
				tick_count = tick_count + 17'd1;
			return 1'b0;
		end
		neg = 1'b1;
		code = NRC_LENGTH;
		o.response_sid = r.service_id;
		if (r.message_length < LEN_MIN) begin
			code = NRC_LENGTH;
		end else if (!sf_supported(sf)) begin
			code = NRC_UNSUPPORTED;
		end else if (sf[0]) begin
			// seed request
			if (lvl_unlocked) begin
				seed_out = 1'b0;
				held_seed = 16'd0;
				neg = 1'b0;
			end else if (!seed_out && r.message_length != LEN_SEED) begin
				code = NRC_LENGTH;
			end else if (!seed_out && tick_count <= {1'b0, cfg_delay}) begin
				code = NRC_DELAY;
			end else begin
				if (!seed_out) begin
					if (!delay_passed)
						fail_count = 8'd0;
					delay_passed = 1'b1;
				end
				seed_out = 1'b1;
				held_seed = r.random_seed;
				saved_sf = sf;
				neg = 1'b0;
			end
			if (!neg) begin
				o.response_sid = SID_SEED_REPLY;
				o.response_sub_function = sf;
				o.carries_seed = 1'b1;
				o.seed_value = held_seed;
			end
		end else if (!seed_out) begin
			code = NRC_SEQUENCE;
		end else begin
			// key against the outstanding seed
			seed_out = 1'b0;
			if (fail_count != ATTEMPT_MAX)
				fail_count = fail_count + 8'd1;
			if (sf != saved_sf + 8'd1) begin
				code = NRC_SEQUENCE;
			end else if (r.message_length != LEN_KEY) begin
				code = NRC_LENGTH;
			end else if (r.received_key == r.expected_key) begin
				fail_count = 8'd0;
				lvl_unlocked = sf_supported(saved_sf);
				neg = 1'b0;
				o.response_sid = r.service_id + SID_POS_OFFSET;
				o.response_sub_function = r.sub_function_byte;
			end else if (fail_count < cfg_limit) begin
				code = NRC_INVALID_KEY;
			end else begin
				tick_count = 17'd0;
				delay_passed = 1'b0;
				code = NRC_ATTEMPTS;
			end
		end
		// positive replies carry a zero code
		o.positive = !neg;
		o.nrc_code = neg ? code : NRC_LENGTH;
		o.unlocked_level = lvl_unlocked;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
		mismatches++;
	endtask

	// compare one reply transaction with the oldest expectation
	task automatic check_reply(rsp_t got);
		rsp_t want;
		if (expected_replies.size() == 0) begin
			report_mismatch("unexpected reply", 32'(got.response_sid), 32'd0);
			return;
		end
		want = expected_replies.pop_front();
		if (got.positive !== want.positive)
			report_mismatch("positive", 32'(got.positive), 32'(want.positive));
		if (got.response_sid !== want.response_sid)
			report_mismatch("response_sid", 32'(got.response_sid),
				32'(want.response_sid));
		if (got.response_sub_function !== want.response_sub_function)
			report_mismatch("response_sub_function", 32'(got.response_sub_function),
				32'(want.response_sub_function));
		if (got.carries_seed !== want.carries_seed)
			report_mismatch("carries_seed", 32'(got.carries_seed),
				32'(want.carries_seed));
		if (got.seed_value !== want.seed_value)
			report_mismatch("seed_value", 32'(got.seed_value), 32'(want.seed_value));
		if (got.nrc_code !== want.nrc_code)
			report_mismatch("nrc_code", 32'(got.nrc_code), 32'(want.nrc_code));
		if (got.unlocked_level !== want.unlocked_level)
			report_mismatch("unlocked_level", 32'(got.unlocked_level),
				32'(want.unlocked_level));
	endtask

	// monitor: sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire <= req_if.valid && req_if.ready;
			if (rsp_if.valid && rsp_if.ready)
				check_reply(rsp_if.data);
			if (req_if.valid && req_if.ready) begin
				if (predict_reply(req_if.data, predicted))
					expected_replies.push_back(predicted);
			end
		end else begin
			req_fire <= 1'b0;
		end
	end

	// driver: offer the next pending transaction at the falling edge
	always @(negedge clk) begin
		if (!req_if.valid || req_fire) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_if.data <= pending_reqs.pop_front();
				req_if.valid <= 1'b1;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// reply side back-pressure
	always @(negedge clk) begin
		rsp_if.ready <= (rsp_hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// long reply hold-off countdown
	always @(negedge clk) begin
		if (hold_start && !hold_loaded) begin
			rsp_hold_cycles <= LONG_HOLD;
			hold_loaded <= 1'b1;
		end else if (rsp_hold_cycles != 0) begin
			rsp_hold_cycles <= rsp_hold_cycles - 1;
		end
	end

	task automatic push_req(logic [7:0] sid, logic [7:0] sfb, logic [11:0] len,
		logic [15:0] rkey, logic [15:0] ekey);
		req_t r;
		r.req_type = ~REQ_TYPE_TICK;
		r.service_id = sid;
		r.sub_function_byte = sfb;
		r.message_length = len;
		// keep the level locked until unlocking is wanted
		r.received_key = (!unlock_ok && rkey == ekey) ? ~ekey : rkey;
		r.random_seed = 16'($urandom);
		r.expected_key = ekey;
		pending_reqs.push_back(r);
		items_queued++;
	endtask

	task automatic push_ticks(int n);
		req_t t;
		repeat (n) begin
			t = req_t'({$urandom, $urandom, 13'($urandom)});
			t.req_type = REQ_TYPE_TICK;
			pending_reqs.push_back(t);
		end
	endtask

	function automatic logic [7:0] with_flag(logic [7:0] sf);
		return {1'($urandom_range(1)), sf[6:0]};
	endfunction

	function automatic logic [7:0] pick_sid();
		return ($urandom_range(7) == 0) ? 8'($urandom) : SID_SECURITY_ACCESS;
	endfunction

	// one random session: mostly seed then key, some broken flows and noise
	task automatic push_session();
		int roll;
		logic [7:0]  seed_sf;
		logic [7:0]  key_sf;
		logic [15:0] k;
		seed_sf = {1'b0, cfg_seed_sf};
		key_sf = seed_sf + 8'd1;
		k = 16'($urandom);
		roll = $urandom_range(99);
		if (roll < 55) begin
			push_ticks(($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(2));
			push_req(pick_sid(), with_flag(seed_sf), LEN_SEED, 16'($urandom), 16'($urandom));
			if ($urandom_range(4) == 0)
				push_req(pick_sid(), with_flag(seed_sf), 12'($urandom), 16'($urandom), k);
			push_req(pick_sid(), with_flag(key_sf), LEN_KEY,
				$urandom_range(1) ? k : 16'($urandom), k);
		end else if (roll < 75) begin
			case ($urandom_range(5))
				0: push_req(pick_sid(), with_flag(key_sf), LEN_KEY, k, k);
				1: begin
					push_req(pick_sid(), with_flag(seed_sf), LEN_SEED, k, k);
					push_req(pick_sid(), with_flag(key_sf), 12'($urandom_range(8)), k, k);
				end
				2: push_req(pick_sid(), with_flag(seed_sf), 12'($urandom), k, k);
				3: push_req(pick_sid(), 8'($urandom), 12'($urandom_range(1)), k, k);
				4: push_req(pick_sid(), 8'($urandom), $urandom_range(1) ? LEN_SEED : LEN_KEY,
					k, k);
				default: begin
					push_req(pick_sid(), with_flag(seed_sf), LEN_SEED, k, k);
					push_ticks($urandom_range(20, 1));
					push_req(pick_sid(), with_flag(seed_sf), LEN_SEED, k, k);
					push_req(pick_sid(), with_flag(key_sf), LEN_KEY, k, k);
				end
			endcase
		end else if (roll < 90) begin
			push_req(8'($urandom), 8'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			push_ticks($urandom_range(20, 1));
		end
	endtask

	// wait until every transaction is taken and every reply has come back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req_if.valid || expected_replies.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] delay, logic [7:0] limit, logic [6:0] seed_sf);
		write_reg(CFG_DELAY_TICKS, delay);
		write_reg(CFG_ATTEMPT_LIMIT, {8'd0, limit});
		write_reg(CFG_SEED_SUBFUNCTION, {9'd0, seed_sf});
		cfg_delay = delay;
		cfg_limit = limit;
		cfg_seed_sf = seed_sf;
	endtask

	task automatic run_random(int n, int send_pct, int recv_pct);
		int first;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		first = items_queued;
		while (items_queued - first < n)
			push_session();
		// leave a seed outstanding for the next setting
		push_req(SID_SECURITY_ACCESS, {1'b0, cfg_seed_sf}, LEN_SEED, 16'd0, 16'd0);
		drain();
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DELAY_TICKS;
		cfg_wdata = '0;
		arst_n = 1'b0;
		cfg_delay = DELAY_TICKS_RST;
		cfg_limit = ATTEMPT_LIMIT_RST;
		cfg_seed_sf = SEED_SUBFUNCTION_RST;
		lvl_unlocked = 1'b0;
		seed_out = 1'b0;
		saved_sf = 8'd0;
		held_seed = 16'd0;
		fail_count = 8'd0;
		tick_count = 17'd0;
		delay_passed = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// locked flows under the reset configuration
		push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h03, 12'd0, 16'h0000, 16'hFFFF);
		push_req(8'h00, 8'h03, 12'd1, 16'hFFFF, 16'h0000);
		push_req(8'hFF, 8'h00, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h80, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h05, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h7F, 12'hFFF, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h04, LEN_KEY, 16'h0000, 16'hFFFF);
		// startup delay boundary
		push_ticks(10000);
		push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		push_ticks(1);
		push_req(SID_SECURITY_ACCESS, 8'h83, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h03, 12'hFFF, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h84, LEN_KEY, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h06, LEN_KEY, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h04, 12'd5, 16'h1234, 16'h1234);
		push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h04, LEN_KEY, 16'hFFFF, 16'h0000);
		push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		drain();

		// timer and attempt counter saturation
		set_config(16'hFFFF, 8'd255, 7'd3);
		push_ticks(131075);
		push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		repeat (300) begin
			push_req(SID_SECURITY_ACCESS, 8'h04, 12'd5, 16'h0000, 16'hFFFF);
			push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		end
		push_req(SID_SECURITY_ACCESS, 8'h04, LEN_KEY, 16'h0000, 16'hFFFF);
		drain();

		// random locked phases; the first one fills the block behind a held reply side
		set_config(16'd0, 8'd1, 7'd1);
		@(posedge clk);
		hold_start = 1'b1;
		run_random(180, 0, 0);
		set_config(16'd5, 8'd255, 7'd127);
		run_random(170, 67, 0);
		set_config(16'd3, 8'd0, 7'd4);
		run_random(120, 0, 67);
		set_config(16'd10, 8'd3, {6'($urandom), 1'b1});
		run_random(170, 31, 31);
		set_config(16'($urandom_range(15)), 8'($urandom_range(5, 1)), 7'd3);
		run_random(170, 67, 0);
		set_config(16'd0, 8'd2, 7'd0);
		run_random(60, 0, 67);
		set_config(16'd2, 8'd3, 7'h41);
		run_random(170, 31, 31);

		// unlock, then the unlocked flows
		unlock_ok = 1'b1;
		set_config(16'd0, 8'd3, 7'd3);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_ticks(1);
		push_req(SID_SECURITY_ACCESS, 8'h03, LEN_SEED, 16'h0000, 16'hFFFF);
		push_req(8'hFF, 8'h84, LEN_KEY, 16'hFFFF, 16'hFFFF);
		push_req(SID_SECURITY_ACCESS, 8'h83, 12'd3, 16'h0000, 16'h0000);
		push_req(SID_SECURITY_ACCESS, 8'h04, LEN_KEY, 16'h0000, 16'h0000);
		push_req(SID_SECURITY_ACCESS, 8'h03, 12'd1, 16'h0000, 16'h0000);
		push_req(SID_SECURITY_ACCESS, 8'h05, LEN_SEED, 16'h0000, 16'h0000);
		drain();
		set_config(16'd1, 8'd3, 7'd3);
		run_random(150, 0, 67);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
